// ===== design/wfsf_pkg.sv =====
// wfsf_pkg: shared types and constants for the frame station filter
// no dependencies; imported by the interfaces and all modules

package wfsf_pkg;

	typedef logic [47:0] mac_t;
	typedef logic [2:0]  verdict_t;
	typedef logic [0:0]  cfg_idx_t;
	typedef logic [4:0]  cfg_data_t;
	typedef logic [4:0]  ap_count_t;
	typedef logic [3:0]  channel_t;
	typedef logic [3:0]  slot_t;
	typedef logic [15:0] frame_len_t;
	typedef logic [7:0]  frame_ctrl_t;

	localparam verdict_t VERDICT_SHORT    = 3'd0;
	localparam verdict_t VERDICT_DEAUTH   = 3'd1;
	localparam verdict_t VERDICT_MGMT     = 3'd2;
	localparam verdict_t VERDICT_FILTERED = 3'd3;
	localparam verdict_t VERDICT_NO_AP    = 3'd4;
	localparam verdict_t VERDICT_STATION  = 3'd5;
	localparam verdict_t VERDICT_TABLE_WR = 3'd6;

	localparam cfg_idx_t CFG_AP_COUNT = 1'b0;
	localparam cfg_idx_t CFG_CHANNEL  = 1'b1;

	localparam ap_count_t AP_COUNT_RST = 5'd0;
	localparam channel_t  CHANNEL_RST  = 4'd1;

	localparam frame_len_t  MIN_HDR_LEN   = 16'd28;
	localparam frame_ctrl_t FC_DEAUTH     = 8'hC0;
	localparam frame_ctrl_t FC_DISASSOC   = 8'hA0;
	localparam frame_ctrl_t FC_BEACON     = 8'h80;
	localparam frame_ctrl_t FC_PROBE_REQ  = 8'h40;
	localparam frame_ctrl_t FC_PROBE_RESP = 8'h50;

	localparam mac_t MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;
	localparam mac_t MAC_ZERO      = 48'h0;

	localparam logic [7:0] STA_TOTAL_MAX = 8'd255;

endpackage

// ===== design/wfsf_if.sv =====
// wfsf_if: valid/ready channel interfaces for frame items and result items
// depends on wfsf_pkg

interface wfsf_frame_if;
	import wfsf_pkg::*;

	logic        valid;
	logic        ready;
	logic        mode;
	frame_len_t  frame_length;
	frame_ctrl_t frame_control;
	mac_t        dest_mac;
	mac_t        src_mac;
	slot_t       entry_index;
	mac_t        ap_bssid;

	modport source (
		output valid, mode, frame_length, frame_control, dest_mac, src_mac, entry_index,
		       ap_bssid,
		input  ready
	);
	modport sink (
		input  valid, mode, frame_length, frame_control, dest_mac, src_mac, entry_index,
		       ap_bssid,
		output ready
	);
endinterface

interface wfsf_result_if;
	import wfsf_pkg::*;

	logic        valid;
	logic        ready;
	verdict_t    verdict;
	mac_t        station_mac;
	logic [3:0]  station_ap;
	channel_t    station_channel;
	logic [31:0] packet_total;
	logic [31:0] deauth_total;
	logic [7:0]  station_total;

	modport source (
		output valid, verdict, station_mac, station_ap, station_channel, packet_total,
		       deauth_total, station_total,
		input  ready
	);
	modport sink (
		input  valid, verdict, station_mac, station_ap, station_channel, packet_total,
		       deauth_total, station_total,
		output ready
	);
endinterface

// ===== design/wfsf_addr_filter.sv =====
// wfsf_addr_filter: flags broadcast, all-zero and listed multicast addresses
// depends on wfsf_pkg

module wfsf_addr_filter (
	input  wfsf_pkg::mac_t mac,
	output logic           rejected
);
	import wfsf_pkg::*;

	logic [7:0] b0, b1, b2, b3, b4, b5;
	logic       mcast;

	assign b0 = mac[47:40];
	assign b1 = mac[39:32];
	assign b2 = mac[31:24];
	assign b3 = mac[23:16];
	assign b4 = mac[15:8];
	assign b5 = mac[7:0];

	always_comb begin
		mcast = 1'b0;
		if (b0 == 8'h33 && b1 == 8'h33)
			mcast = 1'b1;
		if (b0 == 8'h01 && b1 == 8'h80 && b2 == 8'hC2)
			mcast = 1'b1;
		if (b0 == 8'h01 && b1 == 8'h00 && (b2 == 8'h5E || b2 == 8'h0C))
			mcast = 1'b1;
		if (b0 == 8'h01 && b1 == 8'h0C && b2 == 8'hCD &&
		    (b3 == 8'h01 || b3 == 8'h02 || b3 == 8'h04) &&
		    (b4 == 8'h00 || b4 == 8'h01))
			mcast = 1'b1;
		if (b0 == 8'h01 && b1 == 8'h00 && b2 == 8'h0C && b3 == 8'hCC &&
		    b4 == 8'hCC && (b5 == 8'hCC || b5 == 8'hCD))
			mcast = 1'b1;
		if (b0 == 8'h01 && b1 == 8'h1B && b2 == 8'h19 && b3 == 8'h00 &&
		    b4 == 8'h00 && b5 == 8'h00)
			mcast = 1'b1;
	end

	assign rejected = (mac == MAC_BROADCAST) || (mac == MAC_ZERO) || mcast;

endmodule

// ===== design/wifi_frame_station_filter.sv =====
// Frame station filter: takes one captured 802.11 header item (or an access point table
// write) per cycle and returns exactly one result item for each. The item passes an
// input register, is classified by the length and frame control checks, the address
// filters and a parallel compare against the AP_SLOTS table entries below the AP count,
// and lands in the result register; the next item is taken in the same cycle the result
// moves on, so the sustained rate is one item per cycle when the result side does not
// stall. A table write is seen by the item accepted right after it. Packet, deauth and
// station totals are running counters reported with every result.
// depends on wfsf_pkg, wfsf_if and wfsf_addr_filter

module wifi_frame_station_filter #(
	parameter int AP_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  wfsf_pkg::cfg_idx_t  cfg_index,
	input  wfsf_pkg::cfg_data_t cfg_wdata,
	wfsf_frame_if.sink          frame,
	wfsf_result_if.source       result
);
	import wfsf_pkg::*;

	localparam int IDX_W = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;

	// configuration
	ap_count_t ap_count_q;
	channel_t  channel_q;

	// input register
	logic        s1_valid;
	logic        mode_s1;
	frame_len_t  len_s1;
	frame_ctrl_t fc_s1;
	mac_t        dst_s1;
	mac_t        src_s1;
	slot_t       slot_s1;
	mac_t        bssid_s1;

	// state
	mac_t        ap_table_q [AP_SLOTS];
	logic [31:0] pkt_cnt_q;
	logic [31:0] deauth_cnt_q;
	logic [7:0]  sta_cnt_q;

	// result register
	logic       res_valid_q;
	verdict_t   res_verdict_q;
	mac_t       res_mac_q;
	logic [3:0] res_ap_q;
	channel_t   res_ch_q;

	logic                adv_s1;
	logic                load_s1;
	logic                dst_rej, src_rej;
	logic [AP_SLOTS-1:0] src_hit, dst_hit;
	logic [IDX_W-1:0]    src_idx, dst_idx;
	logic                wr_ok;
	logic [IDX_W-1:0]    wr_addr;
	verdict_t            verdict;
	mac_t                sta_mac;
	logic [3:0]          sta_ap;
	channel_t            sta_ch;
	logic                is_frame;

	assign adv_s1      = s1_valid && (!res_valid_q || result.ready);
	assign frame.ready = !s1_valid || adv_s1;
	assign load_s1     = frame.valid && frame.ready;
	assign is_frame    = !mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_count_q <= AP_COUNT_RST;
			channel_q  <= CHANNEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AP_COUNT: ap_count_q <= cfg_wdata;
				CFG_CHANNEL:  channel_q  <= cfg_wdata[3:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (load_s1) begin
			s1_valid <= 1'b1;
		end else if (adv_s1) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1  <= frame.mode;
			len_s1   <= frame.frame_length;
			fc_s1    <= frame.frame_control;
			dst_s1   <= frame.dest_mac;
			src_s1   <= frame.src_mac;
			slot_s1  <= frame.entry_index;
			bssid_s1 <= frame.ap_bssid;
		end
	end

	wfsf_addr_filter u_dst_filter (
		.mac      (dst_s1),
		.rejected (dst_rej)
	);

	wfsf_addr_filter u_src_filter (
		.mac      (src_s1),
		.rejected (src_rej)
	);

	// parallel table compare, lowest matching slot wins
	always_comb begin
		for (int i = 0; i < AP_SLOTS; i++) begin
			src_hit[i] = (ap_table_q[i] == src_s1) && (32'(ap_count_q) > 32'(i));
			dst_hit[i] = (ap_table_q[i] == dst_s1) && (32'(ap_count_q) > 32'(i));
		end
	end

	always_comb begin
		src_idx = '0;
		dst_idx = '0;
		for (int i = AP_SLOTS - 1; i >= 0; i--) begin
			if (src_hit[i])
				src_idx = IDX_W'(i);
			if (dst_hit[i])
				dst_idx = IDX_W'(i);
		end
	end

	always_comb begin
		sta_mac = MAC_ZERO;
		sta_ap  = 4'd0;
		sta_ch  = 4'd0;
		if (mode_s1) begin
			verdict = VERDICT_TABLE_WR;
		end else if (len_s1 < MIN_HDR_LEN) begin
			verdict = VERDICT_SHORT;
		end else if (fc_s1 == FC_DEAUTH || fc_s1 == FC_DISASSOC) begin
			verdict = VERDICT_DEAUTH;
		end else if (fc_s1 == FC_BEACON || fc_s1 == FC_PROBE_REQ || fc_s1 == FC_PROBE_RESP) begin
			verdict = VERDICT_MGMT;
		end else if (dst_rej || src_rej) begin
			verdict = VERDICT_FILTERED;
		end else if (|src_hit) begin
			verdict = VERDICT_STATION;
			sta_mac = dst_s1;
			sta_ap  = 4'(src_idx);
			sta_ch  = channel_q;
		end else if (|dst_hit) begin
			verdict = VERDICT_STATION;
			sta_mac = src_s1;
			sta_ap  = 4'(dst_idx);
			sta_ch  = channel_q;
		end else begin
			verdict = VERDICT_NO_AP;
		end
	end

	assign wr_ok   = 32'(slot_s1) < 32'(AP_SLOTS);
	assign wr_addr = IDX_W'(slot_s1);

	always_ff @(posedge clk) begin
		if (adv_s1 && mode_s1 && wr_ok)
			ap_table_q[wr_addr] <= bssid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_cnt_q    <= 32'd0;
			deauth_cnt_q <= 32'd0;
			sta_cnt_q    <= 8'd0;
		end else if (adv_s1) begin
			if (is_frame)
				pkt_cnt_q <= pkt_cnt_q + 32'd1;
			if (verdict == VERDICT_DEAUTH)
				deauth_cnt_q <= deauth_cnt_q + 32'd1;
			if (verdict == VERDICT_STATION && sta_cnt_q != STA_TOTAL_MAX)
				sta_cnt_q <= sta_cnt_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_verdict_q <= verdict;
			res_mac_q     <= sta_mac;
			res_ap_q      <= sta_ap;
			res_ch_q      <= sta_ch;
		end
	end

	// counters change only together with the result register
	assign result.valid           = res_valid_q;
	assign result.verdict         = res_verdict_q;
	assign result.station_mac     = res_mac_q;
	assign result.station_ap      = res_ap_q;
	assign result.station_channel = res_ch_q;
	assign result.packet_total    = pkt_cnt_q;
	assign result.deauth_total    = deauth_cnt_q;
	assign result.station_total   = sta_cnt_q;

`ifndef SYNTHESIS
	a_sta_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		sta_cnt_q >= $past(sta_cnt_q))
		else $error("station total decreased");

	a_pkt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && is_frame) |=> $stable(pkt_cnt_q))
		else $error("packet total changed without a frame item");

	a_pkt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_frame) |=> pkt_cnt_q == $past(pkt_cnt_q) + 32'd1)
		else $error("packet total did not step");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> frame.ready)
		else $error("input stalled while result register empty");

	a_station_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_verdict_q != VERDICT_STATION) |->
		(res_mac_q == MAC_ZERO && res_ap_q == 4'd0 && res_ch_q == 4'd0))
		else $error("station fields set on a non-station result");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for wifi_frame_station_filter, with directed frame classes,
// table lookups, random traffic over several register settings and output back-pressure
// depends on wfsf_pkg, wfsf_if and the design top level

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wfsf_pkg::*;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;

	typedef struct packed {
		logic        mode;
		frame_len_t  len;
		frame_ctrl_t fc;
		mac_t        dst;
		mac_t        src;
		slot_t       slot;
		mac_t        bssid;
	} frame_t;

	typedef struct packed {
		verdict_t    verdict;
		mac_t        sta;
		logic [3:0]  ap;
		channel_t    ch;
		logic [31:0] pkts;
		logic [31:0] deauths;
		logic [7:0]  stas;
	} result_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_wdata;

	wfsf_frame_if  frame_ch ();
	wfsf_result_if result_ch ();

	wifi_frame_station_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.frame     (frame_ch),
		.result    (result_ch)
	);

	mac_t        bssid_tbl [SLOTS];
	ap_count_t   ap_limit      = AP_COUNT_RST;
	channel_t    radio_channel = CHANNEL_RST;
	logic [31:0] frames_seen   = '0;
	logic [31:0] deauths_seen  = '0;
	logic [7:0]  stations_seen = '0;

	result_t pending_results [$];
	result_t oldest;
	int      mismatch_count = 0;
	int      gap_pct        = 0;
	int      stall_pct      = 0;
	int      hold_req       = 0;
	int      hold_done      = 0;
	int      cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit addr_group(mac_t a);
		logic [7:0] b [6];
		for (int i = 0; i < 6; i++)
			b[i] = a[47 - 8 * i -: 8];
		return (b[0] == 8'h33 && b[1] == 8'h33) ||
			(b[0] == 8'h01 && b[1] == 8'h80 && b[2] == 8'hC2) ||
			(b[0] == 8'h01 && b[1] == 8'h00 && (b[2] == 8'h5E || b[2] == 8'h0C)) ||
			(b[0] == 8'h01 && b[1] == 8'h0C && b[2] == 8'hCD &&
			 (b[3] == 8'h01 || b[3] == 8'h02 || b[3] == 8'h04) &&
			 (b[4] == 8'h00 || b[4] == 8'h01)) ||
			(b[0] == 8'h01 && b[1] == 8'h00 && b[2] == 8'h0C && b[3] == 8'hCC &&
			 b[4] == 8'hCC && (b[5] == 8'hCC || b[5] == 8'hCD)) ||
			(a == 48'h011B_1900_0000);
	endfunction

	function automatic bit addr_blocked(mac_t a);
		return a == MAC_BROADCAST || a == MAC_ZERO || addr_group(a);
	endfunction

	function automatic int find_ap(mac_t a);
		int n;
		n = (ap_limit > SLOTS) ? SLOTS : int'(ap_limit);
		for (int i = 0; i < n; i++)
			if (bssid_tbl[i] == a)
				return i;
		return -1;
	endfunction

	function automatic result_t classify_frame(frame_t f);
		result_t r;
		int      hit;
		mac_t    sta;
		r = '0;
		if (f.mode) begin
			if (int'(f.slot) < SLOTS)
				bssid_tbl[f.slot] = f.bssid;
			r.verdict = VERDICT_TABLE_WR;
		end else begin
			frames_seen = frames_seen + 32'd1;
			if (f.len < MIN_HDR_LEN) begin
				r.verdict = VERDICT_SHORT;
			end else if (f.fc == FC_DEAUTH || f.fc == FC_DISASSOC) begin
				deauths_seen = deauths_seen + 32'd1;
				r.verdict = VERDICT_DEAUTH;
			end else if (f.fc == FC_BEACON || f.fc == FC_PROBE_REQ || f.fc == FC_PROBE_RESP) begin
				r.verdict = VERDICT_MGMT;
			end else if (addr_blocked(f.dst) || addr_blocked(f.src)) begin
				r.verdict = VERDICT_FILTERED;
			end else begin
				hit = find_ap(f.src);
				sta = f.dst;
				if (hit < 0) begin
					hit = find_ap(f.dst);
					sta = f.src;
				end
				if (hit < 0) begin
					r.verdict = VERDICT_NO_AP;
				end else begin
					r.verdict = VERDICT_STATION;
					r.sta = sta;
					r.ap = hit[3:0];
					r.ch = radio_channel;
					if (stations_seen != STA_TOTAL_MAX)
						stations_seen = stations_seen + 8'd1;
				end
			end
		end
		r.pkts = frames_seen;
		r.deauths = deauths_seen;
		r.stas = stations_seen;
		return r;
	endfunction

	function automatic mac_t rand_mac();
		mac_t m;
		m[47:16] = $urandom();
		m[15:0] = 16'($urandom_range(0, 65535));
		return m;
	endfunction

	// individual address: group bit clear, never zero
	function automatic mac_t unicast_mac();
		mac_t m;
		m = rand_mac();
		m[40] = 1'b0;
		if (m == MAC_ZERO)
			m[0] = 1'b1;
		return m;
	endfunction

	function automatic mac_t blocked_mac();
		mac_t m;
		m = rand_mac();
		case ($urandom_range(0, 8))
			0: m = MAC_BROADCAST;
			1: m = MAC_ZERO;
			2: m[47:32] = 16'h3333;
			3: m[47:24] = 24'h0180C2;
			4: m[47:24] = 24'h01005E;
			5: m[47:24] = 24'h01000C;
			6: begin
				m[47:24] = 24'h010CCD;
				m[23:16] = 8'(1 << $urandom_range(0, 2));
				m[15:8] = 8'($urandom_range(0, 1));
			end
			7: begin
				m[47:8] = 40'h01000CCCCC;
				m[7:0] = $urandom_range(0, 1) ? 8'hCC : 8'hCD;
			end
			default: m = 48'h011B_1900_0000;
		endcase
		return m;
	endfunction

	// frame control that reaches the address checks
	function automatic frame_ctrl_t plain_fc();
		frame_ctrl_t fc;
		fc = 8'($urandom_range(0, 255));
		if (fc == FC_DEAUTH || fc == FC_DISASSOC || fc == FC_BEACON ||
		    fc == FC_PROBE_REQ || fc == FC_PROBE_RESP)
			fc = fc ^ 8'h08;
		return fc;
	endfunction

	function automatic frame_t make_frame(frame_len_t len, frame_ctrl_t fc, mac_t dst, mac_t src);
		frame_t f;
		f = '0;
		f.len = len;
		f.fc = fc;
		f.dst = dst;
		f.src = src;
		return f;
	endfunction

	function automatic frame_t table_entry(slot_t slot, mac_t bssid);
		frame_t f;
		f = '0;
		f.mode = 1'b1;
		f.slot = slot;
		f.bssid = bssid;
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int     pick;
		int     n;
		int     k;
		n = (ap_limit > SLOTS) ? SLOTS : int'(ap_limit);
		pick = $urandom_range(0, 99);
		f.mode = 1'b0;
		f.len = 16'($urandom_range(28, 65535));
		f.fc = plain_fc();
		f.dst = unicast_mac();
		f.src = unicast_mac();
		f.slot = 4'($urandom_range(0, SLOTS - 1));
		f.bssid = rand_mac();
		if (pick < 10) begin
			f.mode = 1'b1;
			f.len = 16'($urandom_range(0, 65535));
			f.fc = 8'($urandom_range(0, 255));
			f.dst = rand_mac();
			f.src = rand_mac();
			k = $urandom_range(0, 7);
			if (k == 0)
				f.bssid = bssid_tbl[$urandom_range(0, SLOTS - 1)];
			else if (k != 1)
				f.bssid = unicast_mac();
		end else if (pick < 18) begin
			f.len = 16'($urandom_range(0, 27));
			f.fc = 8'($urandom_range(0, 255));
			f.dst = rand_mac();
			f.src = rand_mac();
		end else if (pick < 26) begin
			f.fc = $urandom_range(0, 1) ? FC_DEAUTH : FC_DISASSOC;
			f.dst = rand_mac();
			f.src = rand_mac();
		end else if (pick < 33) begin
			case ($urandom_range(0, 2))
				0: f.fc = FC_BEACON;
				1: f.fc = FC_PROBE_REQ;
				default: f.fc = FC_PROBE_RESP;
			endcase
			f.src = rand_mac();
		end else if (pick < 43) begin
			case ($urandom_range(0, 2))
				0: f.dst = blocked_mac();
				1: f.src = blocked_mac();
				default: begin
					f.dst = blocked_mac();
					f.src = blocked_mac();
				end
			endcase
			if (n > 0 && $urandom_range(0, 1))
				f.src = bssid_tbl[$urandom_range(0, n - 1)];
		end else if (pick < 55) begin
			f.len = 16'($urandom_range(0, 65535));
			f.fc = 8'($urandom_range(0, 255));
			f.dst = rand_mac();
			f.src = rand_mac();
		end else if (n > 0) begin
			k = $urandom_range(0, n - 1);
			if ($urandom_range(0, 1))
				f.src = bssid_tbl[k];
			else
				f.dst = bssid_tbl[k];
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 1))
					f.dst = bssid_tbl[$urandom_range(0, n - 1)];
				else
					f.src = bssid_tbl[$urandom_range(0, n - 1)];
			end
		end
		return f;
	endfunction

	task automatic push_frame(frame_t f);
		frame_ch.valid <= 1'b1;
		frame_ch.mode <= f.mode;
		frame_ch.frame_length <= f.len;
		frame_ch.frame_control <= f.fc;
		frame_ch.dest_mac <= f.dst;
		frame_ch.src_mac <= f.src;
		frame_ch.entry_index <= f.slot;
		frame_ch.ap_bssid <= f.bssid;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		pending_results.insert(pending_results.size(), classify_frame(f));
		if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic drain();
		frame_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == CFG_AP_COUNT)
			ap_limit = val;
		else
			radio_channel = val[3:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cmp_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// empty table, reset registers
	task automatic test_frame_classes();
		push_frame(make_frame(16'd0, 8'h08, 48'h0200_0000_0001, 48'h0200_0000_0002));
		push_frame(make_frame(16'd27, FC_DEAUTH, 48'h0200_0000_0001, 48'h0200_0000_0002));
		push_frame(make_frame(16'd28, FC_DEAUTH, MAC_BROADCAST, 48'h0200_0000_0002));
		push_frame(make_frame(16'hFFFF, FC_DISASSOC, 48'h0200_0000_0001, MAC_ZERO));
		push_frame(make_frame(16'd100, FC_BEACON, MAC_BROADCAST, 48'h0200_0000_0002));
		push_frame(make_frame(16'd100, FC_PROBE_REQ, 48'h0200_0000_0001, 48'h0200_0000_0002));
		push_frame(make_frame(16'd100, FC_PROBE_RESP, 48'h0200_0000_0001, 48'h0200_0000_0002));
		push_frame(make_frame(16'd28, 8'h08, MAC_BROADCAST, 48'h0200_0000_0002));
		push_frame(make_frame(16'd28, 8'h88, 48'h0200_0000_0001, MAC_ZERO));
		push_frame(make_frame(16'hFFFF, 8'hFF, 48'hFEFF_FFFF_FFFF, 48'h0200_0000_0002));
	endtask

	task automatic test_table_writes();
		push_frame(table_entry(4'd0, 48'h0012_3456_7800));
		push_frame(table_entry(4'd1, 48'h0012_3456_7801));
		push_frame(table_entry(4'd2, 48'h0012_3456_7802));
		push_frame(table_entry(4'd3, 48'hFEFF_FFFF_FFFE));
		push_frame(table_entry(4'd15, MAC_BROADCAST));
		drain();
		write_reg(CFG_AP_COUNT, 5'd4);
		write_reg(CFG_CHANNEL, 5'd14);
	endtask

	task automatic test_station_lookup();
		push_frame(make_frame(16'd28, 8'h08, 48'h3C22_FB10_0001, bssid_tbl[1]));
		push_frame(make_frame(16'd64, 8'h08, bssid_tbl[2], 48'h3C22_FB10_0002));
		push_frame(make_frame(16'd64, 8'h88, bssid_tbl[0], bssid_tbl[3]));
		push_frame(make_frame(16'd64, 8'h08, 48'h3C22_FB10_0003, 48'h3C22_FB10_0004));
		push_frame(table_entry(4'd2, bssid_tbl[0]));
		push_frame(make_frame(16'd64, 8'h08, bssid_tbl[0], 48'h3C22_FB10_0005));
		push_frame(make_frame(16'd64, 8'h08, 48'h3333_0000_0001, bssid_tbl[1]));
		push_frame(make_frame(16'd64, 8'h08, 48'h0180_C200_000E, bssid_tbl[1]));
		push_frame(make_frame(16'd64, 8'h08, 48'h010C_CD04_0100, bssid_tbl[1]));
		push_frame(make_frame(16'd64, 8'h08, bssid_tbl[1], 48'h011B_1900_0000));
		// close to listed group addresses but not on the list
		push_frame(make_frame(16'd64, 8'h08, 48'h010C_CD03_0000, bssid_tbl[1]));
		push_frame(make_frame(16'd64, 8'h08, bssid_tbl[3], 48'h011B_1900_0001));
	endtask

	task automatic test_random_traffic();
		int aps [5]    = '{16, 1, 31, 0, 9};
		int chans [5]  = '{1, 7, 14, 3, 11};
		int gaps [5]   = '{15, 35, 5, 20, 0};
		int stalls [5] = '{15, 5, 35, 20, 10};
		for (int s = 4; s < SLOTS - 1; s++)
			push_frame(table_entry(4'(s), unicast_mac()));
		for (int p = 0; p < 5; p++) begin
			drain();
			write_reg(CFG_AP_COUNT, cfg_data_t'(aps[p]));
			write_reg(CFG_CHANNEL, cfg_data_t'(chans[p]));
			gap_pct = gaps[p];
			stall_pct = stalls[p];
			repeat (150) push_frame(random_frame());
		end
	endtask

	task automatic test_backpressure();
		drain();
		write_reg(CFG_AP_COUNT, 5'd16);
		write_reg(CFG_CHANNEL, 5'd6);
		gap_pct = 0;
		stall_pct = 0;
		hold_req++;
		repeat (40) push_frame(random_frame());
	endtask

	task automatic test_steady_stream();
		gap_pct = 0;
		stall_pct = 0;
		repeat (60) push_frame(random_frame());
	endtask

	// result side ready, with random stalls and one long hold
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_done < hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
				result_ch.ready <= 1'b1;
			end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item with none pending, verdict %0d",
					$time, result_ch.verdict);
				mismatch_count++;
			end else begin
				oldest = pending_results.pop_front();
				cmp_field("verdict", 64'(oldest.verdict), 64'(result_ch.verdict));
				cmp_field("station_mac", 64'(oldest.sta), 64'(result_ch.station_mac));
				cmp_field("station_ap", 64'(oldest.ap), 64'(result_ch.station_ap));
				cmp_field("station_channel", 64'(oldest.ch),
					64'(result_ch.station_channel));
				cmp_field("packet_total", 64'(oldest.pkts), 64'(result_ch.packet_total));
				cmp_field("deauth_total", 64'(oldest.deauths),
					64'(result_ch.deauth_total));
				cmp_field("station_total", 64'(oldest.stas),
					64'(result_ch.station_total));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		frame_ch.valid <= 1'b0;
		frame_ch.mode <= 1'b0;
		frame_ch.frame_length <= '0;
		frame_ch.frame_control <= '0;
		frame_ch.dest_mac <= '0;
		frame_ch.src_mac <= '0;
		frame_ch.entry_index <= '0;
		frame_ch.ap_bssid <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_AP_COUNT;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 20;
		stall_pct = 20;
		test_frame_classes();
		test_table_writes();
		test_station_lookup();
		test_random_traffic();
		test_backpressure();
		test_steady_stream();
		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/wfsf_pkg.sv
design/wfsf_if.sv
design/wfsf_addr_filter.sv
design/wifi_frame_station_filter.sv
tb/tb.sv
